/* rtl/core/vjc_pkg.sv */
// ----------------------------------------------------------------------------
// vjc_pkg
// Shared constants, types and the jet palette for the value-to-color pipeline.
// ----------------------------------------------------------------------------
package vjc_pkg;

	// Palette and fixed-point index format
	localparam int PALETTE_SIZE    = 64;
	localparam int INDEX_FRAC_BITS = 8;

	// Datapath widths
	localparam int DATA_W   = 32;                          // sample and bound width
	localparam int MAG_W    = DATA_W + 1;                  // |sample - low|
	localparam int IDX_W    = $clog2(PALETTE_SIZE);        // palette entry index
	localparam int NUM_W    = MAG_W + IDX_W;               // |sample - low| * (size-1)
	localparam int NUMER_W  = NUM_W + INDEX_FRAC_BITS;     // dividend with fraction bits
	localparam int QUOT_W   = $clog2((PALETTE_SIZE - 1) * (2 ** INDEX_FRAC_BITS));
	localparam int CH_W     = 9;                           // color channel, 0..256
	localparam int WGT_W    = INDEX_FRAC_BITS + 1;         // blend weight, 0..2^frac
	localparam int ACC_W    = CH_W + INDEX_FRAC_BITS + 1;  // blend accumulator

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERPOLATE = 2'd2;

	// Configuration reset values
	localparam logic signed [DATA_W-1:0] RANGE_LOW_RST  = 32'sd0;
	localparam logic signed [DATA_W-1:0] RANGE_HIGH_RST = 32'sd255;
	localparam logic                     INTERP_RST     = 1'b1;

	// Jet ramps: rise and fall points per channel, in palette entries
	localparam int RED_RISE  = 23;
	localparam int RED_FALL  = 71;
	localparam int GRN_RISE  = 7;
	localparam int GRN_FALL  = 55;
	localparam int BLU_RISE  = -9;
	localparam int BLU_FALL  = 39;
	localparam int RAMP_MAX  = 16;
	localparam int RAMP_STEP = 16;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} vjc_rgb_t;

	// Per-word status that travels down the pipe
	typedef struct packed {
		logic empty;   // bounds are equal
		logic clamp;   // index lies at or past the last entry
	} vjc_flags_t;

	// One channel of the palette: triangle ramp, clamped to 0..256
	function automatic logic [CH_W-1:0] jet_ramp(int i, int rise, int fall);
		int up;
		int down;
		int v;
		up   = i - rise;
		down = fall - i;
		v    = (up < down) ? up : down;
		if (v < 0) begin
			v = 0;
		end
		if (v > RAMP_MAX) begin
			v = RAMP_MAX;
		end
		return CH_W'(v * RAMP_STEP);
	endfunction

	function automatic vjc_rgb_t jet_entry(logic [IDX_W-1:0] idx);
		vjc_rgb_t c;
		int       k;
		k       = int'(idx);
		c.red   = jet_ramp(k, RED_RISE, RED_FALL);
		c.green = jet_ramp(k, GRN_RISE, GRN_FALL);
		c.blue  = jet_ramp(k, BLU_RISE, BLU_FALL);
		return c;
	endfunction

endpackage

/* rtl/core/vjc_front.sv */
// ----------------------------------------------------------------------------
// vjc_front
// Input stages: take the distance of the sample from the low bound and scale
// it by the palette's last entry index; flag words that clamp.
// ----------------------------------------------------------------------------
module vjc_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [vjc_pkg::DATA_W-1:0]  sample,
	input  logic signed [vjc_pkg::DATA_W-1:0]  lo,
	input  logic        [vjc_pkg::DATA_W-1:0]  span,
	input  logic                               empty,
	output logic                               out_valid,
	output logic        [vjc_pkg::NUM_W-1:0]   num,
	output vjc_pkg::vjc_flags_t                flags
);
	import vjc_pkg::*;

	logic                     valid_s1, valid_s2, valid_s3;
	logic signed [DATA_W-1:0] sample_s1;
	logic        [MAG_W-1:0]  mag_s2;
	logic        [NUM_W-1:0]  num_s3;
	vjc_flags_t               flags_s3;

	logic signed [MAG_W-1:0]  diff;
	logic        [MAG_W-1:0]  mag_c;
	logic        [NUM_W-1:0]  num_c;
	logic                     clamp_c;

	// Distance from the low bound; samples below it mirror
	always_comb begin
		diff  = MAG_W'(sample_s1) - MAG_W'(lo);
		mag_c = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
	end

	// Scale by the last entry index; a distance at or past the span clamps
	always_comb begin
		num_c   = NUM_W'(mag_s2) * NUM_W'(PALETTE_SIZE - 1);
		clamp_c = (mag_s2 >= MAG_W'(span));
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		sample_s1      <= sample;
		mag_s2         <= mag_c;
		num_s3         <= num_c;
		flags_s3.clamp <= clamp_c;
		flags_s3.empty <= empty;
	end

	assign out_valid = valid_s3;
	assign num       = num_s3;
	assign flags     = flags_s3;

endmodule

/* rtl/core/vjc_div.sv */
// ----------------------------------------------------------------------------
// vjc_div
// Pipelined restoring divider: one quotient bit per stage. The dividend is
// the scaled distance with the index fraction bits appended; only quotients
// below the last entry matter, so QUOT_W bits are produced.
// ----------------------------------------------------------------------------
module vjc_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic        [vjc_pkg::NUM_W-1:0]   num,
	input  vjc_pkg::vjc_flags_t                flags_in,
	input  logic        [vjc_pkg::DATA_W-1:0]  span,
	output logic                               out_valid,
	output logic        [vjc_pkg::QUOT_W-1:0]  quot,
	output vjc_pkg::vjc_flags_t                flags_out
);
	import vjc_pkg::*;

	logic [NUMER_W-1:0] numer;

	// Stage inputs (entry 0 is the module input, entry k is register k)
	logic [DATA_W-1:0]  rem_in   [QUOT_W];
	logic [QUOT_W-1:0]  low_in   [QUOT_W];
	logic [QUOT_W-1:0]  quo_in   [QUOT_W];
	logic               vld_in   [QUOT_W];
	vjc_flags_t         flg_in   [QUOT_W];

	// Stage results
	logic [DATA_W-1:0]  rem_nx   [QUOT_W];
	logic [QUOT_W-1:0]  low_nx   [QUOT_W];
	logic [QUOT_W-1:0]  quo_nx   [QUOT_W];

	// Stage registers
	logic [DATA_W-1:0]  rem_pipe [1:QUOT_W];
	logic [QUOT_W-1:0]  low_pipe [1:QUOT_W];
	logic [QUOT_W-1:0]  quo_pipe [1:QUOT_W];
	logic               vld_pipe [1:QUOT_W];
	vjc_flags_t         flg_pipe [1:QUOT_W];

	logic [DATA_W:0]    trial    [QUOT_W];
	logic               ge       [QUOT_W];

	assign numer = {num, {INDEX_FRAC_BITS{1'b0}}};

	// Route stage inputs
	always_comb begin
		for (int k = 0; k < QUOT_W; k++) begin
			if (k == 0) begin
				rem_in[k] = numer[QUOT_W+DATA_W-1:QUOT_W];
				low_in[k] = numer[QUOT_W-1:0];
				quo_in[k] = '0;
				vld_in[k] = in_valid;
				flg_in[k] = flags_in;
			end else begin
				rem_in[k] = rem_pipe[k];
				low_in[k] = low_pipe[k];
				quo_in[k] = quo_pipe[k];
				vld_in[k] = vld_pipe[k];
				flg_in[k] = flg_pipe[k];
			end
		end
	end

	// Shift in the next dividend bit, subtract the span where it fits
	always_comb begin
		for (int k = 0; k < QUOT_W; k++) begin
			trial[k]  = {rem_in[k], low_in[k][QUOT_W-1]};
			ge[k]     = (trial[k] >= {1'b0, span});
			rem_nx[k] = ge[k] ? DATA_W'(trial[k] - {1'b0, span}) : trial[k][DATA_W-1:0];
			low_nx[k] = low_in[k] << 1;
			quo_nx[k] = (quo_in[k] << 1) | QUOT_W'(ge[k]);
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= QUOT_W; k++) begin
				vld_pipe[k] <= 1'b0;
			end
		end else begin
			for (int k = 1; k <= QUOT_W; k++) begin
				vld_pipe[k] <= vld_in[k-1];
			end
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		for (int k = 1; k <= QUOT_W; k++) begin
			rem_pipe[k] <= rem_nx[k-1];
			low_pipe[k] <= low_nx[k-1];
			quo_pipe[k] <= quo_nx[k-1];
			flg_pipe[k] <= flg_in[k-1];
		end
	end

	assign out_valid = vld_pipe[QUOT_W];
	assign quot      = quo_pipe[QUOT_W];
	assign flags_out = flg_pipe[QUOT_W];

endmodule

/* rtl/core/vjc_blend.sv */
// ----------------------------------------------------------------------------
// vjc_blend
// Output stages: look up the two neighboring palette entries, blend them by
// the index fraction with round-half-up, and register the result word.
// ----------------------------------------------------------------------------
module vjc_blend (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic        [vjc_pkg::QUOT_W-1:0]  quot,
	input  vjc_pkg::vjc_flags_t                flags,
	input  logic                               interp,
	output logic                               done,
	output logic        [vjc_pkg::CH_W-1:0]    red,
	output logic        [vjc_pkg::CH_W-1:0]    green,
	output logic        [vjc_pkg::CH_W-1:0]    blue,
	output logic                               range_empty
);
	import vjc_pkg::*;

	localparam logic [WGT_W-1:0] WGT_FULL = WGT_W'(2 ** INDEX_FRAC_BITS);
	localparam logic [ACC_W-1:0] ROUND    = ACC_W'(2 ** (INDEX_FRAC_BITS - 1));

	logic [IDX_W-1:0]           whole;
	logic [IDX_W-1:0]           sel;
	logic [IDX_W-1:0]           sel_up;
	logic [INDEX_FRAC_BITS-1:0] frac_c;

	logic                       valid_b1;
	vjc_rgb_t                   lo_b1, hi_b1;
	logic [INDEX_FRAC_BITS-1:0] frac_b1;
	logic                       empty_b1;

	logic                       done_q;
	vjc_rgb_t                   rgb_q;
	logic                       empty_q;

	vjc_rgb_t                   mix_c;

	// Weighted sum of two entries, rounded half up
	function automatic logic [CH_W-1:0] mix(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
	                                        logic [INDEX_FRAC_BITS-1:0] f);
		logic [WGT_W-1:0] w_hi;
		logic [WGT_W-1:0] w_lo;
		logic [ACC_W-1:0] acc;
		w_hi = WGT_W'(f);
		w_lo = WGT_FULL - w_hi;
		acc  = ACC_W'(a) * ACC_W'(w_lo) + ACC_W'(b) * ACC_W'(w_hi) + ROUND;
		return CH_W'(acc >> INDEX_FRAC_BITS);
	endfunction

	// Pick the entry and fraction: empty range and clamp force a single entry
	always_comb begin
		whole = IDX_W'(quot >> INDEX_FRAC_BITS);
		if (flags.empty) begin
			sel    = '0;
			frac_c = '0;
		end else if (flags.clamp) begin
			sel    = IDX_W'(PALETTE_SIZE - 1);
			frac_c = '0;
		end else begin
			sel    = whole;
			frac_c = interp ? quot[INDEX_FRAC_BITS-1:0] : '0;
		end
		sel_up = sel + IDX_W'(1);
	end

	// Blend each channel
	always_comb begin
		mix_c.red   = mix(lo_b1.red,   hi_b1.red,   frac_b1);
		mix_c.green = mix(lo_b1.green, hi_b1.green, frac_b1);
		mix_c.blue  = mix(lo_b1.blue,  hi_b1.blue,  frac_b1);
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_b1 <= in_valid;
			done_q   <= valid_b1;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		lo_b1    <= jet_entry(sel);
		hi_b1    <= jet_entry(sel_up);
		frac_b1  <= frac_c;
		empty_b1 <= flags.empty;
		rgb_q    <= mix_c;
		empty_q  <= empty_b1;
	end

	assign done        = done_q;
	assign red         = rgb_q.red;
	assign green       = rgb_q.green;
	assign blue        = rgb_q.blue;
	assign range_empty = empty_q;

endmodule

/* rtl/core/value_to_jet_color.sv */
// ----------------------------------------------------------------------------
// value_to_jet_color
// Maps a signed sample to an RGB false color from a blended jet palette.
// ----------------------------------------------------------------------------
// Takes one sample per clock (busy is low once the first clock edge after
// reset has passed) and returns one color word per sample, in order, from a
// pipeline of three input stages, one divider stage per index bit, a palette
// lookup stage and a blend stage. done is high for exactly one cycle with red,
// green, blue and range_empty; the receiver must take the word in that cycle,
// there is no back-pressure. The bounds are ordered internally; equal bounds
// give the first palette entry with range_empty set. Write the configuration
// only while no word is in flight.
// ----------------------------------------------------------------------------
module value_to_jet_color (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [vjc_pkg::DATA_W-1:0]     sample,
	output logic                                  done,
	output logic        [vjc_pkg::CH_W-1:0]       red,
	output logic        [vjc_pkg::CH_W-1:0]       green,
	output logic        [vjc_pkg::CH_W-1:0]       blue,
	output logic                                  range_empty,
	input  logic                                  cfg_we,
	input  logic        [vjc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [vjc_pkg::DATA_W-1:0]     cfg_wdata
);
	import vjc_pkg::*;

	logic signed [DATA_W-1:0] range_low_q;
	logic signed [DATA_W-1:0] range_high_q;
	logic                     interp_q;
	logic signed [DATA_W-1:0] lo_q;
	logic        [DATA_W-1:0] span_q;
	logic                     empty_q;
	logic                     busy_q;

	logic                     accept;
	logic                     front_valid;
	logic [NUM_W-1:0]         front_num;
	vjc_flags_t               front_flags;
	logic                     div_valid;
	logic [QUOT_W-1:0]        div_quot;
	vjc_flags_t               div_flags;

	// Hold busy through reset only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	// Write configuration registers; drop writes past the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
			interp_q     <= INTERP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_LOW:   range_low_q  <= cfg_wdata;
				REG_RANGE_HIGH:  range_high_q <= cfg_wdata;
				REG_INTERPOLATE: interp_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Order the bounds and form the span
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q    <= RANGE_LOW_RST;
			span_q  <= DATA_W'(RANGE_HIGH_RST - RANGE_LOW_RST);
			empty_q <= 1'b0;
		end else begin
			if (range_low_q > range_high_q) begin
				lo_q   <= range_high_q;
				span_q <= range_low_q - range_high_q;
			end else begin
				lo_q   <= range_low_q;
				span_q <= range_high_q - range_low_q;
			end
			empty_q <= (range_low_q == range_high_q);
		end
	end

	vjc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.sample    (sample),
		.lo        (lo_q),
		.span      (span_q),
		.empty     (empty_q),
		.out_valid (front_valid),
		.num       (front_num),
		.flags     (front_flags)
	);

	vjc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.num       (front_num),
		.flags_in  (front_flags),
		.span      (span_q),
		.out_valid (div_valid),
		.quot      (div_quot),
		.flags_out (div_flags)
	);

	vjc_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (div_valid),
		.quot        (div_quot),
		.flags       (div_flags),
		.interp      (interp_q),
		.done        (done),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.range_empty (range_empty)
	);

endmodule
